// ----- rtl/set_intersection_unique_top_macros.svh -----
`ifndef SET_INTERSECTION_UNIQUE_TOP_MACROS_SVH
`define SET_INTERSECTION_UNIQUE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sis_pkg.sv -----
`timescale 1ns / 1ps

package sis_pkg;

    localparam int DATA_W = 32;

    localparam logic MODE_A = 1'b0;
    localparam logic MODE_B = 1'b1;

    // One loaded word.
    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } item_t;

    // One result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     none_found;
        logic                     overflow;
    } res_t;

endpackage

// ----- rtl/sis_ram.sv -----
`timescale 1ns / 1ps

module sis_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [sis_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [sis_pkg::DATA_W-1:0] rdata
);
    import sis_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/sis_ctrl.sv -----
`timescale 1ns / 1ps

module sis_ctrl #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input side
    input  logic                       s_valid,
    output logic                       s_ready,
    input  sis_pkg::item_t             s_item,
    // result side
    output logic                       m_valid,
    input  logic                       m_ready,
    output sis_pkg::res_t              m_res,
    // store ports, one shared read address
    output logic                       a_we,
    output logic                       b_we,
    output logic                       f_we,
    output logic [AW-1:0]              waddr,
    output logic [sis_pkg::DATA_W-1:0] wdata,
    output logic [AW-1:0]              raddr,
    input  logic [sis_pkg::DATA_W-1:0] a_rdata,
    input  logic [sis_pkg::DATA_W-1:0] b_rdata,
    input  logic [sis_pkg::DATA_W-1:0] f_rdata
);
    import sis_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [9:0] {
        ST_LOAD   = 10'b0000000001,
        ST_A_RD   = 10'b0000000010,
        ST_A_LAT  = 10'b0000000100,
        ST_B_RD   = 10'b0000001000,
        ST_B_CMP  = 10'b0000010000,
        ST_F_RD   = 10'b0000100000,
        ST_F_CMP  = 10'b0001000000,
        ST_O_RD   = 10'b0010000000,
        ST_O_LD   = 10'b0100000000,
        ST_O_WAIT = 10'b1000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     a_cnt_reg, a_cnt_next;
    logic [CW-1:0]     b_cnt_reg, b_cnt_next;
    logic [CW-1:0]     f_cnt_reg, f_cnt_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg, out_res_next;
    logic [DATA_W-1:0] x_reg, x_next;
    logic [DATA_W-1:0] cmp_data;
    logic              hit;

    // The one comparator: candidate against a B entry or a found entry.
    assign cmp_data = (state_reg == ST_B_CMP) ? b_rdata : f_rdata;
    assign hit      = (x_reg == cmp_data);

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

    always_comb
    begin
        state_next     = state_reg;
        a_cnt_next     = a_cnt_reg;
        b_cnt_next     = b_cnt_reg;
        f_cnt_next     = f_cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        x_next         = x_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        f_we           = 1'b0;
        waddr          = a_cnt_reg[AW-1:0];
        wdata          = s_item.value;
        raddr          = j_reg[AW-1:0];

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_valid)
                begin
                    if (s_item.mode == MODE_A)
                    begin
                        if (a_cnt_reg < DEPTH_C)
                        begin
                            a_we       = 1'b1;
                            a_cnt_next = a_cnt_reg + ONE_C;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        waddr = b_cnt_reg[AW-1:0];
                        if (b_cnt_reg < DEPTH_C)
                        begin
                            b_we       = 1'b1;
                            b_cnt_next = b_cnt_reg + ONE_C;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_item.last)
                    begin
                        i_next     = '0;
                        f_cnt_next = '0;
                        state_next = ST_A_RD;
                    end
                end
            end
            ST_A_RD:
            begin
                raddr = i_reg[AW-1:0];
                if (i_reg == a_cnt_reg)
                begin
                    if (f_cnt_reg == '0)
                    begin
                        out_valid_next          = 1'b1;
                        out_res_next.value_res  = '0;
                        out_res_next.last_res   = 1'b1;
                        out_res_next.none_found = 1'b1;
                        out_res_next.overflow   = ovf_reg;
                        state_next              = ST_O_WAIT;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = ST_O_RD;
                    end
                end
                else
                begin
                    state_next = ST_A_LAT;
                end
            end
            ST_A_LAT:
            begin
                x_next     = a_rdata;
                j_next     = '0;
                state_next = ST_B_RD;
            end
            ST_B_RD:
            begin
                if (j_reg == b_cnt_reg)
                begin
                    i_next     = i_reg + ONE_C;
                    state_next = ST_A_RD;
                end
                else
                begin
                    state_next = ST_B_CMP;
                end
            end
            ST_B_CMP:
            begin
                if (hit)
                begin
                    j_next     = '0;
                    state_next = ST_F_RD;
                end
                else
                begin
                    j_next     = j_reg + ONE_C;
                    state_next = ST_B_RD;
                end
            end
            ST_F_RD:
            begin
                if (j_reg == f_cnt_reg)
                begin
                    // New distinct value: append it.
                    f_we       = 1'b1;
                    waddr      = f_cnt_reg[AW-1:0];
                    wdata      = x_reg;
                    f_cnt_next = f_cnt_reg + ONE_C;
                    i_next     = i_reg + ONE_C;
                    state_next = ST_A_RD;
                end
                else
                begin
                    state_next = ST_F_CMP;
                end
            end
            ST_F_CMP:
            begin
                if (hit)
                begin
                    i_next     = i_reg + ONE_C;
                    state_next = ST_A_RD;
                end
                else
                begin
                    j_next     = j_reg + ONE_C;
                    state_next = ST_F_RD;
                end
            end
            ST_O_RD:
            begin
                state_next = ST_O_LD;
            end
            ST_O_LD:
            begin
                out_valid_next          = 1'b1;
                out_res_next.value_res  = f_rdata;
                out_res_next.last_res   = ((j_reg + ONE_C) == f_cnt_reg);
                out_res_next.none_found = 1'b0;
                out_res_next.overflow   = ovf_reg;
                state_next              = ST_O_WAIT;
            end
            ST_O_WAIT:
            begin
                if (m_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_res_reg.last_res)
                    begin
                        a_cnt_next = '0;
                        b_cnt_next = '0;
                        f_cnt_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        j_next     = j_reg + ONE_C;
                        state_next = ST_O_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            f_cnt_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_cnt_reg     <= a_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            f_cnt_reg     <= f_cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        x_reg       <= x_next;
    end

endmodule

// ----- rtl/set_intersection_unique_top.sv -----
`timescale 1ns / 1ps
`include "set_intersection_unique_top_macros.svh"

// Set intersection without repeats. Stream words into set A (tuser = 0) or
// set B (tuser = 1), one word per cycle; the word with tlast = 1 is stored
// too and closes the job. The block then drops s_axis_tready and walks the
// sets with one shared comparator and one read port per store: for every A
// entry, it fetches the entry, compares it with the B entries up to the
// first match, and on a match compares it with the values already found,
// appending it if it is new; the walk ends after the last A entry. Results
// follow, held by any downstream stall, in order of first appearance in
// A, the final one with tlast. An empty intersection gives one word with
// none_found set and data 0. Words beyond DEPTH per set are dropped and
// overflow is set on every result of that job. Counts clear when the final
// result is taken; the block then accepts again. No clearing pass is needed
// after reset.
module set_intersection_unique_top #(
    parameter int DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [0:0]  s_axis_tuser,   // [0] mode (0 = set A, 1 = set B)
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_res
    output logic [1:0]  m_axis_tuser,   // [0] none_found, [1] overflow
    output logic        m_axis_tlast
);
    import sis_pkg::*;

    // Address bits and a count wide enough to hold DEPTH itself.
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t             s_item;
    res_t              m_res;
    logic              a_we, b_we, f_we;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] a_rdata, b_rdata, f_rdata;

    // Unpack the input word.
    assign s_item.mode  = s_axis_tuser[0];
    assign s_item.value = s_axis_tdata;
    assign s_item.last  = s_axis_tlast;

    // Pack the result word.
    assign m_axis_tdata    = m_res.value_res;
    assign m_axis_tlast    = m_res.last_res;
    assign m_axis_tuser[0] = m_res.none_found;
    assign m_axis_tuser[1] = m_res.overflow;

    // Set A, set B and the list of distinct common values found so far.
    sis_ram #(.DEPTH(DEPTH), .AW(AW)) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (a_rdata)
    );

    sis_ram #(.DEPTH(DEPTH), .AW(AW)) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (b_rdata)
    );

    sis_ram #(.DEPTH(DEPTH), .AW(AW)) u_found_store (
        .clk   (clk),
        .we    (f_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (f_rdata)
    );

    // Load, compare walk and result output.
    sis_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res),
        .a_we    (a_we),
        .b_we    (b_we),
        .f_we    (f_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr   (raddr),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata),
        .f_rdata (f_rdata)
    );

    // Loading and result output never overlap.
    `SIS_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "load open while result pending")
    // An empty result is a single final word carrying zero.
    `SIS_ASSERT_NOW(a_none_final, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tlast && (m_axis_tdata == 32'd0), "bad empty result")
    // The closing word starts the walk, so loading stops.
    `SIS_ASSERT_NEXT(a_close_stops, s_axis_tvalid && s_axis_tready && s_axis_tlast,
        !s_axis_tready, "load still open after closing word")
    // The final result ends the job.
    `SIS_ASSERT_NEXT(a_final_ends, m_axis_tvalid && m_axis_tready && m_axis_tlast,
        !m_axis_tvalid, "result after final word")

endmodule
